// ===== design/ale_pkg.sv =====
// Shared types and constants for the array list engine.
// No dependencies; used by array_list_engine and by the bench.
package ale_pkg;

    localparam int ALE_CAPACITY = 128;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_DELVAL = 3'd3,
        CMD_GET    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_BADPOS   = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_INS_WR,
        ST_SHIFT_DN,
        ST_GET
    } state_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [7:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         found_index;
        logic signed [31:0] read_data;
        logic [7:0]         count;
    } res_t;

endpackage

// ===== design/ale_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No package dependencies.
module ale_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/array_list_engine.sv =====
// Array list engine top level: command FSM around the list store RAM.
// Depends on ale_pkg and ale_ram.
//
// Usage: drive request and raise start while busy is low; the request is
// taken at that clock edge. Exactly one result follows per request: done is
// high for one cycle with result valid, and the result must be taken then.
// A new request may be issued in the same cycle that done is shown.
// Rejected requests and unknown commands finish straight from idle. Get
// does one RAM read. Insert shifts the entries at and above the rank up
// by one, then writes the value. Delete at rank shifts the entries above
// it down by one. Find scans from index 0 until a match or the end of the
// list; delete value scans as find does, then shifts down from the match.
// The RAM has one read and one write port; each shift step moves one entry
// per cycle. Requests are processed one at a time. Reset empties the list
// (count 0); the RAM contents are not cleared and only entries below count
// are read.
module array_list_engine
    import ale_pkg::*;
#(
    parameter int CAPACITY = ALE_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output res_t result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 8) ? CW : 8) + 1;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  ptr_reg, ptr_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [2:0]     cmd_reg, cmd_next;
    logic [31:0]    val_reg, val_next;
    logic           wpend_reg, wpend_next;
    logic [AW-1:0]  waddr_reg, waddr_next;
    logic           cmp_reg, cmp_next;
    logic [AW-1:0]  cmp_addr_reg, cmp_addr_next;
    logic           done_reg, done_next;
    status_t        status_reg, status_next;
    logic [AW-1:0]  fidx_reg, fidx_next;
    logic [31:0]    rdata_reg, rdata_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [31:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [31:0]    ram_rdata;

    logic [XW-1:0]  pos_x;
    logic [XW-1:0]  cnt_x;
    logic           match;

    ale_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (32)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we    = wpend_reg || (state_reg == ST_INS_WR);
    assign ram_waddr = wpend_reg ? waddr_reg : idx_reg;
    assign ram_wdata = wpend_reg ? ram_rdata : val_reg;

    assign pos_x = XW'(request.position);
    assign cnt_x = XW'(count_reg);
    assign match = cmp_reg && (ram_rdata == val_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        wpend_next    = 1'b0;
        waddr_next    = waddr_reg;
        cmp_next      = 1'b0;
        cmp_addr_next = cmp_addr_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        fidx_next     = fidx_reg;
        rdata_next    = rdata_reg;
        ram_raddr     = ptr_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = request.command;
                    val_next   = request.value;
                    fidx_next  = '0;
                    rdata_next = '0;
                    unique case (request.command)
                        CMD_INSERT:
                        begin
                            if (cnt_x >= XW'(CAPACITY))
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_FULL;
                            end
                            else if (pos_x == '0 || pos_x > cnt_x + XW'(1))
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                idx_next   = AW'(pos_x - XW'(1));
                                ptr_next   = count_reg;
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_x == '0 || pos_x > cnt_x)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                ptr_next   = CW'(pos_x - XW'(1));
                                state_next = ST_SHIFT_DN;
                            end
                        end
                        CMD_FIND, CMD_DELVAL:
                        begin
                            ptr_next   = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_GET:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                ram_raddr  = AW'(pos_x);
                                state_next = ST_GET;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    fidx_next = cmp_addr_reg;
                    if (cmd_reg == CMD_FIND)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_OK;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = CW'(cmp_addr_reg);
                        state_next = ST_SHIFT_DN;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    ram_raddr     = ptr_reg[AW-1:0];
                    cmp_next      = 1'b1;
                    cmp_addr_next = ptr_reg[AW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NOTFOUND;
                    fidx_next   = '0;
                    state_next  = ST_IDLE;
                end
            end

            ST_SHIFT_UP:
            begin
                if (ptr_reg[AW-1:0] != idx_reg)
                begin
                    ram_raddr  = AW'(ptr_reg - CW'(1));
                    wpend_next = 1'b1;
                    waddr_next = ptr_reg[AW-1:0];
                    ptr_next   = ptr_reg - CW'(1);
                end
                else
                begin
                    state_next = ST_INS_WR;
                end
            end

            ST_INS_WR:
            begin
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = STAT_OK;
                state_next  = ST_IDLE;
            end

            ST_SHIFT_DN:
            begin
                if (({1'b0, ptr_reg} + (CW+1)'(1)) < {1'b0, count_reg})
                begin
                    ram_raddr  = AW'(ptr_reg + CW'(1));
                    wpend_next = 1'b1;
                    waddr_next = ptr_reg[AW-1:0];
                    ptr_next   = ptr_reg + CW'(1);
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                    state_next  = ST_IDLE;
                end
            end

            ST_GET:
            begin
                rdata_next  = ram_rdata;
                done_next   = 1'b1;
                status_next = STAT_OK;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            wpend_reg <= 1'b0;
            cmp_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpend_reg <= wpend_next;
            cmp_reg   <= cmp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        idx_reg      <= idx_next;
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        waddr_reg    <= waddr_next;
        cmp_addr_reg <= cmp_addr_next;
        status_reg   <= status_next;
        fidx_reg     <= fidx_next;
        rdata_reg    <= rdata_next;
    end

    assign busy               = (state_reg != ST_IDLE);
    assign done               = done_reg;
    assign result.status      = status_reg;
    assign result.found_index = 7'(fidx_reg);
    assign result.read_data   = rdata_reg;
    assign result.count       = 8'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result issued while a request is still in flight");

    a_wpend_shift: assert property (@(posedge clk) disable iff (!rst_n)
        wpend_reg |-> (state_reg == ST_SHIFT_UP || state_reg == ST_SHIFT_DN))
        else $error("shift write pending outside a shift");

    a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg)
        else $error("count changed without a result");

endmodule

// ===== bench/ale_list_mirror_pkg.sv =====
// Scoreboard for the array list engine: a mirror of the list and its count.
// Depends on ale_pkg for the request and reply types and the codes.
package ale_list_mirror_pkg;

    import ale_pkg::*;

    class list_mirror;

        logic signed [31:0] entries [ALE_CAPACITY];
        int unsigned        held;
        res_t               awaited_replies [$];
        int unsigned        failures;

        function new();
            held = 0;
            failures = 0;
        endfunction

        function void drop_entry(int unsigned idx);
            int unsigned k;
            for (k = idx; k + 1 < held; k++)
                entries[k] = entries[k + 1];
            held--;
        endfunction

        function void note_request(req_t r);
            res_t        reply;
            int unsigned pos;
            int unsigned k;
            bit          hit;
            reply = '0;
            pos = r.position;
            hit = 1'b0;
            case (r.command)
                CMD_INSERT:
                begin
                    if (held >= ALE_CAPACITY)
                        reply.status = STAT_FULL;
                    else if (pos < 1 || pos > held + 1)
                        reply.status = STAT_BADPOS;
                    else
                    begin
                        for (k = held; k > pos - 1; k--)
                            entries[k] = entries[k - 1];
                        entries[pos - 1] = r.value;
                        held++;
                    end
                end
                CMD_DELETE:
                begin
                    if (pos < 1 || pos > held)
                        reply.status = STAT_BADPOS;
                    else
                        drop_entry(pos - 1);
                end
                CMD_FIND, CMD_DELVAL:
                begin
                    for (k = 0; k < held && !hit; k++)
                    begin
                        if (entries[k] == r.value)
                        begin
                            hit = 1'b1;
                            reply.found_index = 7'(k);
                        end
                    end
                    if (!hit)
                        reply.status = STAT_NOTFOUND;
                    else if (r.command == CMD_DELVAL)
                        drop_entry(reply.found_index);
                end
                CMD_GET:
                begin
                    if (pos >= held)
                        reply.status = STAT_BADPOS;
                    else
                        reply.read_data = entries[pos];
                end
                default:
                    ;
            endcase
            reply.count = 8'(held);
            awaited_replies.push_back(reply);
        endfunction

        function void compare_reply(res_t got);
            res_t want;
            if (awaited_replies.size() == 0)
            begin
                $error("reply with none awaited: status %0d count %0d", got.status, got.count);
                failures++;
                return;
            end
            want = awaited_replies.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.found_index !== want.found_index)
            begin
                $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
                failures++;
            end
            if (got.read_data !== want.read_data)
            begin
                $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
                failures++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                failures++;
            end
        endfunction

    endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for array_list_engine: directed and random list commands.
// Depends on ale_pkg and ale_list_mirror_pkg; replies checked as they arrive.
module tb_top
    import ale_pkg::*, ale_list_mirror_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned DRAIN_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    res_t result;

    list_mirror  sb = new();
    int unsigned cycle_count = 0;

    array_list_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.compare_reply(result);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input logic [2:0] cmd, input logic [7:0] pos,
                         input logic signed [31:0] val);
        req_t r;
        r.command = cmd;
        r.position = pos;
        r.value = val;
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5, 6: return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int unsigned items, input int unsigned ins_pct,
                              input bit gaps);
        int unsigned        roll;
        int unsigned        held;
        int unsigned        pos;
        logic [2:0]         cmd;
        logic signed [31:0] v;
        repeat (items)
        begin
            held = sb.held;
            v = pick_value();
            pos = $urandom_range(255);
            roll = $urandom_range(99);
            if (roll < ins_pct)
            begin
                cmd = CMD_INSERT;
                if ($urandom_range(9) != 0)
                    pos = $urandom_range(held + 1, 1);
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 30)
                begin
                    cmd = CMD_DELETE;
                    if (held > 0 && $urandom_range(9) != 0)
                        pos = $urandom_range(held, 1);
                end
                else if (roll < 50)
                    cmd = CMD_FIND;
                else if (roll < 70)
                    cmd = CMD_DELVAL;
                else if (roll < 97)
                begin
                    cmd = CMD_GET;
                    if (held > 0 && $urandom_range(9) != 0)
                        pos = $urandom_range(held - 1);
                end
                else
                    cmd = 3'($urandom_range(7, CMD_GET + 1));
                if ((cmd == CMD_FIND || cmd == CMD_DELVAL) && held > 0
                    && $urandom_range(3) != 0)
                    v = sb.entries[$urandom_range(held - 1)];
            end
            if (gaps && $urandom_range(99) < 13)
            begin
                start <= 1'b0;
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(40, 1)) @(negedge clk);
                else
                    repeat ($urandom_range(4, 1)) @(negedge clk);
            end
            issue(cmd, pos[7:0], v);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list: accesses rejected; then directed list commands
        issue(CMD_GET, 8'd0, 32'sd0);
        issue(CMD_DELETE, 8'd1, 32'sd0);
        issue(CMD_FIND, 8'd0, 32'sd0);
        issue(CMD_DELVAL, 8'd0, -32'sd1);
        issue(CMD_INSERT, 8'd0, 32'sd5);
        issue(CMD_INSERT, 8'd2, 32'sd5);
        issue(CMD_INSERT, 8'd1, 32'sh7fffffff);
        issue(CMD_INSERT, 8'd2, 32'sh80000000);
        issue(CMD_INSERT, 8'd1, 32'sd0);
        issue(CMD_INSERT, 8'd4, -32'sd1);
        issue(CMD_INSERT, 8'd255, 32'sd7);
        issue(CMD_FIND, 8'd0, -32'sd1);
        issue(CMD_FIND, 8'd0, 32'sh80000000);
        issue(CMD_GET, 8'd0, 32'sd0);
        issue(CMD_GET, 8'd3, 32'sd0);
        issue(CMD_GET, 8'd4, 32'sd0);
        issue(CMD_GET, 8'd255, 32'sd0);
        issue(CMD_DELETE, 8'd0, 32'sd0);
        issue(CMD_DELETE, 8'd5, 32'sd0);
        issue(CMD_DELETE, 8'd2, 32'sd0);
        issue(CMD_DELVAL, 8'd0, 32'sh7fffffff);
        issue(CMD_DELVAL, 8'd0, 32'sd12345);
        for (int c = CMD_GET + 1; c < 8; c++)
            issue(3'(c), 8'($urandom_range(255)), $urandom);

        run_random(300, 45, 1'b1);
        run_random(250, 85, 1'b1);
        run_random(200, 40, 1'b0);
        run_random(350, 10, 1'b1);
        run_random(300, 50, 1'b1);
        run_random(250, 85, 1'b1);
        run_random(250, 20, 1'b1);

        start <= 1'b0;
        while (sb.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ale_pkg.sv
design/ale_ram.sv
design/array_list_engine.sv
bench/ale_list_mirror_pkg.sv
bench/tb_top.sv
